### rtl/core/mcsa_pkg.sv
package mcsa_pkg;

   // field widths
   localparam int unsigned BASE_W   = 15;
   localparam int unsigned DEPTH_W  = 12;
   localparam int unsigned MIP_W    = 4;
   localparam int unsigned COUNT_W  = 12;
   localparam int unsigned IDX_W    = 11;
   localparam int unsigned SLICE_W  = 12;
   localparam int unsigned SUB_W    = 15;
   localparam int unsigned OFF_W    = 32;
   localparam int unsigned AREA_W   = 2 * BASE_W;
   localparam int unsigned TEXELS_W = 29;

   // layout constants
   localparam int unsigned LEVEL_LIMIT      = 15;
   localparam int unsigned MIN_SLICE_TEXELS = 4;

   // divider steps for the slice wrap: one quotient bit per step
   localparam int unsigned DIV_STEPS = SLICE_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // register file
   localparam int unsigned APB_ADDR_W = 5;
   localparam int unsigned APB_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_BASE_WIDTH     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BASE_HEIGHT    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BASE_DEPTH     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_REQUESTED_MIPS = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ARRAY_COUNT    = 3'd4;

   typedef struct packed {
      logic [IDX_W-1:0]   layer_index;
      logic [MIP_W-1:0]   level;
      logic [SLICE_W-1:0] slice_index;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [SUB_W-1:0]    subresource_number;
      logic [OFF_W-1:0]    subresource_offset;
      logic [BASE_W-1:0]   lod_width;
      logic [BASE_W-1:0]   lod_height;
      logic [DEPTH_W-1:0]  lod_depth;
      logic [OFF_W-1:0]    slice_offset;
      logic [TEXELS_W-1:0] slice_texels;
      logic [MIP_W-1:0]    mip_count;
   } rsp_type;

   typedef struct packed {
      logic [BASE_W-1:0]  base_width;
      logic [BASE_W-1:0]  base_height;
      logic [DEPTH_W-1:0] base_depth;
      logic [MIP_W-1:0]   requested_mips;
      logic [COUNT_W-1:0] array_count;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic reject;
      logic area;
      logic size;
      logic mul;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range;
      logic last_level;
      logic div_done;
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_AREA,
      ST_SIZE,
      ST_MUL,
      ST_FINISH
   } state_type;

endpackage

### rtl/core/mcsa_csr.sv
module mcsa_csr import mcsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[APB_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BASE_WIDTH:     cfg_in.base_width     = pwdata[BASE_W-1:0];
            REG_BASE_HEIGHT:    cfg_in.base_height    = pwdata[BASE_W-1:0];
            REG_BASE_DEPTH:     cfg_in.base_depth     = pwdata[DEPTH_W-1:0];
            REG_REQUESTED_MIPS: cfg_in.requested_mips = pwdata[MIP_W-1:0];
            REG_ARRAY_COUNT:    cfg_in.array_count    = pwdata[COUNT_W-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_width     <= BASE_W'(1);
         cfg_ff.base_height    <= BASE_W'(1);
         cfg_ff.base_depth     <= DEPTH_W'(1);
         cfg_ff.requested_mips <= '0;
         cfg_ff.array_count    <= COUNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_BASE_WIDTH:     prdata = APB_DATA_W'(cfg_ff.base_width);
         REG_BASE_HEIGHT:    prdata = APB_DATA_W'(cfg_ff.base_height);
         REG_BASE_DEPTH:     prdata = APB_DATA_W'(cfg_ff.base_depth);
         REG_REQUESTED_MIPS: prdata = APB_DATA_W'(cfg_ff.requested_mips);
         REG_ARRAY_COUNT:    prdata = APB_DATA_W'(cfg_ff.array_count);
         default:            prdata = '0;
      endcase
   end

endmodule

### rtl/core/mcsa_ctrl.sv
module mcsa_ctrl import mcsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.in_range) begin
               state_in = ST_AREA;
            end else begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_AREA: begin
            cmd.area = 1'b1;
            state_in = ST_SIZE;
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = sts.last_level ? ST_MUL : ST_AREA;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the slice remainder is out
            if (sts.div_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/core/mcsa_dp.sv
module mcsa_dp import mcsa_pkg::*; #(
   parameter int unsigned LEVEL_CAP   = LEVEL_LIMIT,
   parameter int unsigned SLICE_FLOOR = MIN_SLICE_TEXELS
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // base dimension shifted down by a level, never below one
   function automatic logic [BASE_W-1:0] dim_at(input logic [BASE_W-1:0] base,
                                                input logic [MIP_W-1:0]  lvl);
      logic [BASE_W-1:0] v;
      v = base >> lvl;
      return (v == '0) ? BASE_W'(1) : v;
   endfunction

   // request fields
   logic [IDX_W-1:0]     idx_ff;
   logic [MIP_W-1:0]     lvl_ff;
   // slice divider
   logic [SLICE_W-1:0]   z_ff;
   logic [SLICE_W-1:0]   rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   // mip walk
   logic [MIP_W-1:0]     m_ff;
   logic [AREA_W-1:0]    area_ff;
   logic [OFF_W-1:0]     layer_ff;
   logic [OFF_W-1:0]     pre_ff;
   // final products
   logic [OFF_W-1:0]     prod_ff;
   logic [AREA_W-1:0]    area_lvl_ff;
   logic [SUB_W-1:0]     subnum_ff;
   // result
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic [BASE_W-1:0]    max_wh;
   logic [BASE_W-1:0]    max_dim;
   logic [MIP_W-1:0]     mips;
   logic [BASE_W-1:0]    w_m, h_m, d_m_full;
   logic [BASE_W-1:0]    w_l, h_l, d_l_full;
   logic [DEPTH_W-1:0]   d_m, d_l;
   logic [AREA_W-1:0]    area_min;
   logic [OFF_W-1:0]     sub_size;
   logic [SLICE_W:0]     div_trial;
   logic [SLICE_W:0]     div_diff;

   // mip count: bit width of the largest dimension, capped
   always_comb begin
      max_wh  = (cfg.base_width > cfg.base_height) ? cfg.base_width : cfg.base_height;
      max_dim = (max_wh > BASE_W'(cfg.base_depth)) ? max_wh : BASE_W'(cfg.base_depth);
      mips = '0;
      for (int i = 0; i < BASE_W; i++) begin
         if (max_dim[i]) mips = MIP_W'(i + 1);
      end
      if ((cfg.requested_mips != '0) && (cfg.requested_mips < mips))
         mips = cfg.requested_mips;
      if (32'(mips) > LEVEL_CAP)
         mips = MIP_W'(LEVEL_CAP);
   end

   // dimensions at the walk level and at the requested level
   assign w_m      = dim_at(cfg.base_width, m_ff);
   assign h_m      = dim_at(cfg.base_height, m_ff);
   assign d_m_full = dim_at(BASE_W'(cfg.base_depth), m_ff);
   assign d_m      = d_m_full[DEPTH_W-1:0];
   assign w_l      = dim_at(cfg.base_width, lvl_ff);
   assign h_l      = dim_at(cfg.base_height, lvl_ff);
   assign d_l_full = dim_at(BASE_W'(cfg.base_depth), lvl_ff);
   assign d_l      = d_l_full[DEPTH_W-1:0];

   // subresource size from the registered area
   always_comb begin
      logic [AREA_W+DEPTH_W-1:0] full;
      area_min = (area_ff < AREA_W'(SLICE_FLOOR)) ? AREA_W'(SLICE_FLOOR) : area_ff;
      full     = (AREA_W+DEPTH_W)'(area_min) * (AREA_W+DEPTH_W)'(d_m);
      sub_size = full[OFF_W-1:0];
   end

   // restoring divider step
   assign div_trial = {rem_ff, z_ff[SLICE_W-1]};
   assign div_diff  = div_trial - (SLICE_W+1)'(d_l);

   // status
   assign sts.in_range   = (COUNT_W'(idx_ff) < cfg.array_count) && (lvl_ff < mips);
   assign sts.last_level = (m_ff == (mips - MIP_W'(1)));
   assign sts.div_done   = (div_cnt_ff == '0);

   // request capture and slice divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= req_data.layer_index;
         lvl_ff <= req_data.level;
         z_ff   <= req_data.slice_index;
         rem_ff <= '0;
      end else if (div_cnt_ff != '0) begin
         z_ff   <= {z_ff[SLICE_W-2:0], 1'b0};
         rem_ff <= div_diff[SLICE_W] ? div_trial[SLICE_W-1:0] : div_diff[SLICE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.load) begin
         div_cnt_ff <= DIV_CNT_W'(DIV_STEPS);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   // mip walk: an area step then a size step for each level
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ff     <= '0;
         layer_ff <= '0;
         pre_ff   <= '0;
      end else if (cmd.size) begin
         m_ff     <= m_ff + MIP_W'(1);
         layer_ff <= layer_ff + sub_size;
         if (m_ff < lvl_ff) pre_ff <= pre_ff + sub_size;
      end
      if (cmd.area) area_ff <= AREA_W'(w_m) * AREA_W'(h_m);
   end

   // layer product, area of the requested mip, subresource number
   always_ff @(posedge clock) begin
      logic [IDX_W+OFF_W-1:0]   p_layer;
      logic [IDX_W+MIP_W-1:0]   p_sub;
      if (cmd.mul) begin
         p_layer     = (IDX_W+OFF_W)'(idx_ff) * (IDX_W+OFF_W)'(layer_ff);
         p_sub       = (IDX_W+MIP_W)'(idx_ff) * (IDX_W+MIP_W)'(mips);
         prod_ff     <= p_layer[OFF_W-1:0];
         area_lvl_ff <= AREA_W'(w_l) * AREA_W'(h_l);
         subnum_ff   <= p_sub[SUB_W-1:0] + SUB_W'(lvl_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      logic [AREA_W+SLICE_W-1:0] p_slice;
      if (cmd.reject) begin
         rsp_ff <= '0;
      end else if (cmd.finish) begin
         p_slice                   = (AREA_W+SLICE_W)'(area_lvl_ff) *
                                     (AREA_W+SLICE_W)'(rem_ff);
         rsp_ff.ok                 <= 1'b1;
         rsp_ff.subresource_number <= subnum_ff;
         rsp_ff.subresource_offset <= prod_ff + pre_ff;
         rsp_ff.lod_width          <= w_l;
         rsp_ff.lod_height         <= h_l;
         rsp_ff.lod_depth          <= d_l;
         rsp_ff.slice_offset       <= p_slice[OFF_W-1:0];
         rsp_ff.slice_texels       <= area_lvl_ff[TEXELS_W-1:0];
         rsp_ff.mip_count          <= mips;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.reject | cmd.finish;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/mip_chain_subresource_address.sv
// Channel  Ports                                     Handshake
// request  start, busy, req_data                     taken when start & !busy
// response rsp_valid, rsp_data                       one-cycle strobe, no back-pressure
// config   psel penable pwrite paddr pwdata prdata   APB, pready tied high
//
// A request runs the mip walk, an area state and a size state per level, while
// the 12-step slice divider runs beside it. Out-of-range requests are answered
// from the check state without the walk.
// Reset is synchronous; registers return to width/height/depth 1, full chain,
// one layer. The receiver cannot stall; busy drops as the response shows.
module mip_chain_subresource_address import mcsa_pkg::*; #(
   parameter int unsigned LEVEL_CAP   = LEVEL_LIMIT,
   parameter int unsigned SLICE_FLOOR = MIN_SLICE_TEXELS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // response
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   mcsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mcsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   mcsa_dp #(
      .LEVEL_CAP   (LEVEL_CAP),
      .SLICE_FLOOR (SLICE_FLOOR)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
